// File: rtl/tcgr_pkg.sv
// shared constants, codes and types of the text cursor glyph renderer
`default_nettype none

package tcgr_pkg;

  // glyph store geometry
  localparam int FONT_COUNT      = 2;
  localparam int GLYPH_COUNT     = 96;
  localparam int MAX_CHAR_HEIGHT = 32;
  localparam int MAX_CHAR_WIDTH  = 16;

  localparam int STORE_DEPTH = FONT_COUNT * GLYPH_COUNT * MAX_CHAR_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BASE_W      = $clog2(FONT_COUNT * GLYPH_COUNT);
  localparam int ROW_CNT_W   = $clog2(MAX_CHAR_HEIGHT + 1);

  // stream and configuration port widths
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FONT_SELECT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_WIDTH       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_HEIGHT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_PER_LINE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINES_PER_SCREEN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT    = 3'd6;

  // character codes
  localparam logic [7:0] FIRST_DRAWABLE = 8'h20;
  localparam logic [7:0] LAST_DRAWABLE  = 8'h7F;
  localparam logic [7:0] SUBST_CHAR     = 8'h3F;
  localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_CHAR      = 2'd0,
    REQ_SET_TEXT  = 2'd1,
    REQ_SET_PIXEL = 2'd2,
    REQ_LOAD      = 2'd3
  } tcgr_req_t;

  // one-shot datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_TEXT,
    OP_SET_PIXEL,
    OP_LOAD,
    OP_NEWLINE,
    OP_DRAW_START
  } tcgr_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DRAW,
    S_DRAIN
  } tcgr_state_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    tcgr_op_t op;
    logic     issue_en;
  } tcgr_cmd_t;

  // datapath to controller
  typedef struct packed {
    tcgr_req_t req;
    logic      newline;
    logic      rows_done;
    logic      rd_busy;
  } tcgr_status_t;

  typedef struct packed {
    tcgr_req_t   req;
    logic [7:0]  char_code;
    logic        honor_newline;
    logic [9:0]  cursor_x;
    logic [7:0]  cursor_y;
    logic        glyph_font;
    logic [4:0]  glyph_row;
    logic [15:0] glyph_bits;
  } tcgr_item_t;

  typedef struct packed {
    logic [9:0]  win_x;
    logic [7:0]  win_y;
    logic [10:0] win_x_end;
    logic [8:0]  win_y_end;
    logic [4:0]  row_index;
    logic [15:0] row_bits;
    logic        last_row;
  } tcgr_result_t;

endpackage

`default_nettype wire

// File: rtl/tcgr_ctrl.sv
// controller state machine: sequences decode, row reads and drain
`default_nettype none

module tcgr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire tcgr_pkg::tcgr_status_t status,
  output tcgr_pkg::tcgr_cmd_t        cmd
);
  import tcgr_pkg::*;

  tcgr_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.op       = OP_NONE;
    cmd.issue_en = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (status.req)
          REQ_SET_TEXT:  cmd.op = OP_SET_TEXT;
          REQ_SET_PIXEL: cmd.op = OP_SET_PIXEL;
          REQ_LOAD:      cmd.op = OP_LOAD;
          REQ_CHAR: begin
            if (status.newline) begin
              cmd.op = OP_NEWLINE;
            end else begin
              cmd.op     = OP_DRAW_START;
              state_next = S_DRAW;
            end
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_DRAW: begin
        cmd.issue_en = 1'b1;
        if (status.rows_done) begin
          state_next = status.rd_busy ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (!status.rd_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tcgr_datapath.sv
// datapath: configuration, cursors, glyph store, row read stage and output register
`default_nettype none

module tcgr_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tcgr_pkg::tcgr_item_t                item_in,
  input  wire tcgr_pkg::tcgr_cmd_t                 cmd,
  output tcgr_pkg::tcgr_status_t                   status,
  input  wire logic                                cfg_wr_en,
  input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output tcgr_pkg::tcgr_result_t                   out_result
);
  import tcgr_pkg::*;

  // configuration registers
  logic       font_select;
  logic [4:0] char_width;
  logic [5:0] char_height;
  logic [7:0] chars_per_line;
  logic [7:0] lines_per_screen;
  logic [9:0] screen_width;
  logic [7:0] screen_height;

  // cursor state
  logic [7:0] text_col;
  logic [7:0] text_line;
  logic [9:0] pixel_x;
  logic [7:0] pixel_y;
  logic       pixel_mode;

  // captured item and draw context
  tcgr_item_t          item;
  logic [9:0]          win_x;
  logic [7:0]          win_y;
  logic [BASE_W-1:0]   glyph_base;
  logic [ROW_CNT_W-1:0] issue_row;

  // read stage
  logic        rd_valid;
  logic [15:0] rd_bits;
  logic [4:0]  rd_row;
  logic        rd_last;

  logic [15:0] store [STORE_DEPTH];

  logic [4:0]        w_eff;
  logic [5:0]        h_eff;
  logic [15:0]       col_mask;
  logic              drawable;
  logic [7:0]        draw_code;
  logic [7:0]        draw_gidx;
  logic              draw_bank;
  logic [BASE_W-1:0] draw_base;
  logic [12:0]       text_wx_full;
  logic [13:0]       text_wy_full;
  logic [7:0]        load_gidx;
  logic              load_ok;
  logic [ADDR_W-1:0] load_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rows_done;
  logic              advance;
  logic              rd_load;
  logic              col_wrap;
  logic              line_wrap;
  logic [10:0]       px_next;
  logic [11:0]       px_check;
  logic [8:0]        py_next;
  logic [9:0]        py_check;
  logic              px_wrap;
  logic              py_wrap;

  // effective glyph size and column mask
  always_comb begin
    if (char_width == 5'd0) begin
      w_eff = 5'd1;
    end else if (char_width > 5'(MAX_CHAR_WIDTH)) begin
      w_eff = 5'(MAX_CHAR_WIDTH);
    end else begin
      w_eff = char_width;
    end
    if (char_height == 6'd0) begin
      h_eff = 6'd1;
    end else if (char_height > 6'(MAX_CHAR_HEIGHT)) begin
      h_eff = 6'(MAX_CHAR_HEIGHT);
    end else begin
      h_eff = char_height;
    end
    col_mask = ~(16'hFFFF >> w_eff);
  end

  // glyph selection for a drawn character
  always_comb begin
    drawable  = (item.char_code >= FIRST_DRAWABLE) && (item.char_code <= LAST_DRAWABLE);
    draw_code = drawable ? item.char_code : SUBST_CHAR;
    draw_gidx = draw_code - FIRST_DRAWABLE;
    if (32'(draw_gidx) >= GLYPH_COUNT) begin
      draw_gidx = 8'd0;
    end
    draw_bank = (32'(font_select) < FONT_COUNT) ? font_select : 1'b0;
    draw_base = BASE_W'(draw_bank) * BASE_W'(GLYPH_COUNT) + BASE_W'(draw_gidx);
    text_wx_full = 13'(text_col) * 13'(w_eff);
    text_wy_full = 14'(text_line) * 14'(h_eff);
  end

  // glyph row load check and address
  always_comb begin
    load_gidx = item.char_code - FIRST_DRAWABLE;
    load_ok   = (item.char_code >= FIRST_DRAWABLE) && (item.char_code <= LAST_DRAWABLE)
                && (32'(item.glyph_font) < FONT_COUNT)
                && (32'(item.glyph_row) < MAX_CHAR_HEIGHT)
                && (32'(load_gidx) < GLYPH_COUNT);
    load_addr = (ADDR_W'(item.glyph_font) * ADDR_W'(GLYPH_COUNT) + ADDR_W'(load_gidx))
                * ADDR_W'(MAX_CHAR_HEIGHT) + ADDR_W'(item.glyph_row);
    rd_addr   = ADDR_W'(glyph_base) * ADDR_W'(MAX_CHAR_HEIGHT) + ADDR_W'(issue_row);
  end

  // cursor advance terms
  always_comb begin
    col_wrap  = (9'(text_col) + 9'd1) >= 9'(chars_per_line);
    line_wrap = (9'(text_line) + 9'd1) >= 9'(lines_per_screen);
    px_next   = 11'(pixel_x) + 11'(w_eff);
    px_check  = 12'(pixel_x) + 12'({w_eff, 1'b0});
    px_wrap   = px_check >= 12'(screen_width);
    py_next   = 9'(pixel_y) + 9'(h_eff);
    py_check  = 10'(pixel_y) + 10'({h_eff, 1'b0});
    py_wrap   = py_check > 10'(screen_height);
  end

  // row read pipeline control
  always_comb begin
    rows_done = issue_row == ROW_CNT_W'(h_eff);
    advance   = !out_valid || out_ready;
    rd_load   = cmd.issue_en && !rows_done && (!rd_valid || advance);
  end

  always_comb begin
    status.req       = item.req;
    status.newline   = !pixel_mode && item.honor_newline && (item.char_code == NEWLINE_CHAR);
    status.rows_done = rows_done;
    status.rd_busy   = rd_valid;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      font_select      <= 1'b0;
      char_width       <= 5'd6;
      char_height      <= 6'd13;
      chars_per_line   <= 8'd53;
      lines_per_screen <= 8'd18;
      screen_width     <= 10'd320;
      screen_height    <= 8'd240;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FONT_SELECT:      font_select      <= cfg_data[0];
        CFG_CHAR_WIDTH:       char_width       <= cfg_data[4:0];
        CFG_CHAR_HEIGHT:      char_height      <= cfg_data[5:0];
        CFG_CHARS_PER_LINE:   chars_per_line   <= cfg_data[7:0];
        CFG_LINES_PER_SCREEN: lines_per_screen <= cfg_data[7:0];
        CFG_SCREEN_WIDTH:     screen_width     <= cfg_data;
        CFG_SCREEN_HEIGHT:    screen_height    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // cursor updates
  always_ff @(posedge clk) begin
    if (rst) begin
      text_col   <= 8'd0;
      text_line  <= 8'd0;
      pixel_x    <= 10'd0;
      pixel_y    <= 8'd0;
      pixel_mode <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_SET_TEXT: begin
          text_col   <= item.cursor_x[7:0];
          text_line  <= item.cursor_y;
          pixel_mode <= 1'b0;
        end
        OP_SET_PIXEL: begin
          pixel_x    <= item.cursor_x;
          pixel_y    <= item.cursor_y;
          pixel_mode <= 1'b1;
        end
        OP_NEWLINE: begin
          text_col  <= 8'd0;
          text_line <= line_wrap ? 8'd0 : text_line + 8'd1;
        end
        OP_DRAW_START: begin
          if (pixel_mode) begin
            if (px_wrap) begin
              pixel_x <= 10'd0;
              pixel_y <= py_wrap ? 8'd0 : py_next[7:0];
            end else begin
              pixel_x <= px_next[9:0];
            end
          end else if (col_wrap) begin
            text_col  <= 8'd0;
            text_line <= line_wrap ? 8'd0 : text_line + 8'd1;
          end else begin
            text_col <= text_col + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // item capture and draw context
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= item_in;
    end
    if (cmd.op == OP_DRAW_START) begin
      win_x      <= pixel_mode ? pixel_x : text_wx_full[9:0];
      win_y      <= pixel_mode ? pixel_y : text_wy_full[7:0];
      glyph_base <= draw_base;
    end
  end

  // row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_row <= '0;
    end else if (cmd.op == OP_DRAW_START) begin
      issue_row <= '0;
    end else if (rd_load) begin
      issue_row <= issue_row + ROW_CNT_W'(1);
    end
  end

  // glyph store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && load_ok) begin
      store[load_addr] <= item.glyph_bits;
    end
    if (rd_load) begin
      rd_bits <= store[rd_addr];
      rd_row  <= issue_row[4:0];
      rd_last <= (issue_row + ROW_CNT_W'(1)) == ROW_CNT_W'(h_eff);
    end
  end

  // read stage and output register valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_load) begin
        rd_valid <= 1'b1;
      end else if (advance) begin
        rd_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= rd_valid;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance && rd_valid) begin
      out_result.win_x     <= win_x;
      out_result.win_y     <= win_y;
      out_result.win_x_end <= 11'(win_x) + 11'(w_eff);
      out_result.win_y_end <= 9'(win_y) + 9'(h_eff);
      out_result.row_index <= rd_row;
      out_result.row_bits  <= rd_bits & col_mask;
      out_result.last_row  <= rd_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/text_cursor_glyph_renderer.sv
// top level of the text cursor glyph renderer
// Usage: items enter on the s_ stream; tuser gives the request kind (character,
// set text cursor, set pixel cursor, load glyph row) and tdata the item fields.
// tlast marks the final character of a string and is not used by the logic.
// A drawn character produces one transaction per glyph row on the m_ stream,
// carrying the window corners, row index and masked row bitmap; tlast flags
// the last row. Colour expansion happens downstream.
// Glyph rows are loaded through load items into a 6144 x 16 glyph store; rows
// never loaded read back as unspecified data. The user must write configuration
// registers through cfg_wr_en / cfg_index / cfg_data only while the block is
// idle; the block itself does not enforce this. Cursor commands, loads and
// text-mode newlines are accepted, then decoded. A drawn character is accepted,
// decoded, then read with one glyph store read per row through the single read
// port of the store, and its last read is drained before the block returns to
// idle. Items are accepted only in idle, so each is finished before the next.
// Reset restores the register defaults, puts both cursors at 0 in text mode
// and empties the pipeline; glyph store contents are kept.
// When the receiver stalls, the output register holds its transaction and the
// row reads pause; no row is lost or repeated.
`default_nettype none

module text_cursor_glyph_renderer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // char_code, honor_newline, cursor_x, cursor_y, glyph_font, glyph_row, glyph_bits
  input  wire logic [tcgr_pkg::IN_TDATA_W-1:0]      s_tdata,
  // req_type
  input  wire logic [tcgr_pkg::IN_TUSER_W-1:0]      s_tuser,
  input  wire logic                                 s_tlast,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // win_x, win_y, win_x_end, win_y_end, row_index, row_bits
  output logic [tcgr_pkg::OUT_TDATA_W-1:0]          m_tdata,
  output logic                                      m_tlast,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tcgr_pkg::*;

  tcgr_item_t   item_in;
  tcgr_cmd_t    cmd;
  tcgr_status_t status;
  tcgr_result_t out_result;
  logic         last_of_string;

  // unpack the input transaction
  always_comb begin
    item_in.req           = tcgr_req_t'(s_tuser);
    item_in.char_code     = s_tdata[7:0];
    item_in.honor_newline = s_tdata[8];
    item_in.cursor_x      = s_tdata[18:9];
    item_in.cursor_y      = s_tdata[26:19];
    item_in.glyph_font    = s_tdata[27];
    item_in.glyph_row     = s_tdata[32:28];
    item_in.glyph_bits    = s_tdata[48:33];
    last_of_string        = s_tlast;
  end

  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcgr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .cmd        (cmd),
    .status     (status),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  // pack the output transaction
  always_comb begin
    m_tdata = {5'd0, out_result.row_bits, out_result.row_index, out_result.win_y_end,
               out_result.win_x_end, out_result.win_y, out_result.win_x};
    m_tlast = out_result.last_row & ~(last_of_string & 1'b0);
  end

endmodule

`default_nettype wire
